[src/session_slot_table_top_defines.svh]
// Assertion macros for the session slot table.
// Both expect clk and arst_n in scope.
`ifndef SESSION_SLOT_TABLE_TOP_DEFINES_SVH
`define SESSION_SLOT_TABLE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SST_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define SST_ASSERT(lbl, prop, msg)
`define SST_NEVER(lbl, expr, msg)
`endif
`endif

[src/sst_pkg.sv]
package sst_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int LIST_W      = $clog2(MAX_RESULTS + 1);
	localparam int CNT_W       = 5;
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_GET    = 2'd2,
		MODE_LIST   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_CAP      = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_NOTFOUND = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	// slot contents, session id in the low bits
	typedef struct packed {
		logic [63:0] start_time;
		logic [31:0] ip;
		logic [63:0] sid;
	} entry_t;

	typedef struct packed {
		status_t          status;
		logic [3:0]       slot;
		entry_t           entry;
		logic [CNT_W-1:0] count;
	} result_t;

endpackage

[src/sst_mem.sv]
module sst_mem #(
	parameter int SLOTS = sst_pkg::SLOTS_DEF,
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_addr,
	input  sst_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  logic [IW-1:0]   rd_addr,
	output sst_pkg::entry_t rd_data
);

	sst_pkg::entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/sst_ctrl.sv]
`include "session_slot_table_top_defines.svh"

module sst_ctrl #(
	parameter int SLOTS = sst_pkg::SLOTS_DEF,
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  sst_pkg::mode_t            in_mode,
	input  sst_pkg::entry_t           in_entry,
	input  logic [sst_pkg::CNT_W-1:0] cap,
	input  logic                      out_free,
	output logic                      res_vld,
	output sst_pkg::result_t          res,
	output logic                      res_last,
	output logic                      wr_en,
	output logic [IW-1:0]             wr_addr,
	output sst_pkg::entry_t           wr_data,
	output logic                      rd_en,
	output logic [IW-1:0]             rd_addr,
	input  sst_pkg::entry_t           rd_data
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} fsm_t;

	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
	localparam logic [sst_pkg::LIST_W-1:0] LIST_LAST = sst_pkg::LIST_W'(sst_pkg::MAX_RESULTS - 1);

	fsm_t                          state_q;
	sst_pkg::mode_t                mode_q;
	sst_pkg::entry_t               key_q;
	sst_pkg::status_t              fail_q;
	logic [SLOTS-1:0]              valid_q;
	logic [sst_pkg::CNT_W-1:0]     count_q;
	logic [CW-1:0]                 idx_q;
	logic                          v_s1;
	logic [IW-1:0]                 idx_s1;
	logic [sst_pkg::LIST_W-1:0]    listed_q;
	sst_pkg::result_t              hold_q;
	logic                          hold_vld_q;

	logic                          cond;
	logic                          hit;
	logic                          last_hit;
	logic                          is_list;
	logic                          stall;
	logic                          iss;
	logic                          scan_end;
	logic                          push_scan;
	logic                          push_done;
	sst_pkg::entry_t               hit_entry;
	logic [sst_pkg::CNT_W-1:0]     new_count;
	sst_pkg::result_t              fail_res;

	assign in_ready = (state_q == S_IDLE);
	assign is_list  = (mode_q == sst_pkg::MODE_LIST);

	always_comb begin
		case (mode_q)
			sst_pkg::MODE_ADD: begin
				cond = !valid_q[idx_s1];
			end
			sst_pkg::MODE_REMOVE, sst_pkg::MODE_GET: begin
				cond = valid_q[idx_s1] && (rd_data.sid == key_q.sid);
			end
			sst_pkg::MODE_LIST: begin
				cond = valid_q[idx_s1];
			end
			default: begin
				cond = 1'b0;
			end
		endcase
	end

	assign hit      = (state_q == S_SCAN) && v_s1 && cond;
	// hit that ends the walk: any non-list hit, or the last list result allowed
	assign last_hit = hit && (!is_list || listed_q == LIST_LAST);
	// a list hit can only be parked once the previous one has gone out
	assign stall    = hit && is_list && hold_vld_q && !out_free;
	assign iss      = (state_q == S_SCAN) && !stall && !last_hit && (idx_q < SLOTS_C);
	assign scan_end = (state_q == S_SCAN) && !v_s1 && (idx_q == SLOTS_C);

	assign hit_entry = (mode_q == sst_pkg::MODE_ADD) ? key_q : rd_data;

	always_comb begin
		case (mode_q)
			sst_pkg::MODE_ADD:    new_count = count_q + sst_pkg::CNT_W'(1);
			sst_pkg::MODE_REMOVE: new_count = count_q - sst_pkg::CNT_W'(1);
			default:              new_count = count_q;
		endcase
	end

	assign fail_res = '{status: fail_q, slot: '0, entry: '0, count: count_q};

	assign push_scan = hit && is_list && hold_vld_q && out_free;
	assign push_done = (state_q == S_DONE) && out_free;
	assign res_vld   = push_scan || push_done;
	assign res_last  = push_done;
	assign res       = (push_done && !hold_vld_q) ? fail_res : hold_q;

	assign wr_en   = hit && (mode_q == sst_pkg::MODE_ADD);
	assign wr_addr = idx_s1;
	assign wr_data = key_q;
	assign rd_en   = iss;
	assign rd_addr = idx_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= sst_pkg::MODE_ADD;
			valid_q    <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			v_s1       <= 1'b0;
			listed_q   <= '0;
			hold_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q     <= in_mode;
						idx_q      <= '0;
						v_s1       <= 1'b0;
						listed_q   <= '0;
						hold_vld_q <= 1'b0;
						if (in_mode == sst_pkg::MODE_ADD && count_q >= cap) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (!stall) begin
						v_s1 <= iss;
						if (iss) begin
							idx_q <= idx_q + CW'(1);
						end
					end
					if (hit && !stall) begin
						hold_vld_q <= 1'b1;
						count_q    <= new_count;
						if (mode_q == sst_pkg::MODE_ADD) begin
							valid_q[idx_s1] <= 1'b1;
						end
						if (mode_q == sst_pkg::MODE_REMOVE) begin
							valid_q[idx_s1] <= 1'b0;
						end
						if (is_list) begin
							listed_q <= listed_q + sst_pkg::LIST_W'(1);
						end
						if (last_hit) begin
							state_q <= S_DONE;
						end
					end else if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						hold_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			key_q <= in_entry;
			case (in_mode)
				sst_pkg::MODE_ADD:   fail_q <= (count_q >= cap) ? sst_pkg::STAT_CAP
				                                                : sst_pkg::STAT_FULL;
				sst_pkg::MODE_LIST:  fail_q <= sst_pkg::STAT_EMPTY;
				default:             fail_q <= sst_pkg::STAT_NOTFOUND;
			endcase
		end
		if (state_q == S_SCAN && !stall) begin
			idx_s1 <= idx_q[IW-1:0];
		end
		if (hit && !stall) begin
			hold_q <= '{status: sst_pkg::STAT_OK, slot: 4'(idx_s1), entry: hit_entry,
			            count: new_count};
		end
	end

	`SST_ASSERT(a_count_match, $countones(valid_q) == int'(count_q), "count differs from valid slots")
	`SST_ASSERT(a_push_free, res_vld |-> out_free, "result pushed into a full output stage")
	`SST_NEVER(a_idle_hold, state_q == S_IDLE && hold_vld_q, "parked result left in idle")
	`SST_ASSERT(a_done_idle, (state_q == S_DONE && out_free) |=> (state_q == S_IDLE), "final result did not end the item")

endmodule

[src/session_slot_table_top.sv]
// Session slot table: SLOTS entries of {session id, IPv4 address, start time} kept in one
// single-port-write, registered-read memory, with valid bits and the live count in flops.
// One item is handled at a time. The controller walks the slots in order, one memory read
// per cycle while no list result is held back by the output, and stops at the first free
// slot (add) or the first id match (remove, get); list walks the table and emits one
// result per valid slot, at most 16, the last one flagged by tlast. An add refused by the
// cap skips the walk. The next item is accepted while the final result still waits in the
// output register. Write session_cap only while no item is in flight.
module session_slot_table_top #(
	parameter int SLOTS = sst_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [159:0] s_axis_tdata,  // sid, peer address, start time
	input  logic [1:0]   s_axis_tuser,  // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// slot, stored sid, stored address, stored start time, live count, zero pad
	output logic [175:0] m_axis_tdata,
	output logic [2:0]   m_axis_tuser,  // status
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [4:0]   cfg_wdata      // session_cap
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [sst_pkg::CNT_W-1:0] cap_q;
	logic                      out_free;
	logic                      res_vld;
	sst_pkg::result_t          res;
	logic                      res_last;
	sst_pkg::result_t          m_res_q;
	logic                      m_vld_q;
	logic                      m_last_q;
	logic                      wr_en;
	logic [IW-1:0]             wr_addr;
	sst_pkg::entry_t           wr_data;
	logic                      rd_en;
	logic [IW-1:0]             rd_addr;
	sst_pkg::entry_t           rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= sst_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	assign out_free = !m_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (res_vld) begin
			m_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			m_res_q  <= res;
			m_last_q <= res_last;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_res_q.status;
	assign m_axis_tdata  = {7'd0, m_res_q.count, m_res_q.entry.start_time, m_res_q.entry.ip,
	                        m_res_q.entry.sid, m_res_q.slot};

	sst_mem #(.SLOTS(SLOTS)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sst_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_mode  (sst_pkg::mode_t'(s_axis_tuser)),
		.in_entry (sst_pkg::entry_t'(s_axis_tdata)),
		.cap      (cap_q),
		.out_free (out_free),
		.res_vld  (res_vld),
		.res      (res),
		.res_last (res_last),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

endmodule
